/* rtl/core/osstk_pkg.sv */
// Shared types and codes for the order statistic stack.
// Holds the operation and status codes and the cell command and flag types.
// No dependencies; used by osstk_cell and order_statistic_stack.
package osstk_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_SEL  = 2'd2;

	// Status codes of a result transaction.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP
	} cell_cmd_t;

	// Status a cell reports to its neighbors and to the result logic.
	typedef struct packed {
		logic valid;
		logic le;
		logic top_hit;
		logic sel_hit;
	} cell_flags_t;

endpackage

/* rtl/core/order_statistic_stack.sv */
// Order statistic stack: a bounded LIFO of key/value entries that also answers rank queries.
// An accepted transaction passes through EXEC, where the chain updates, and READ, which
// gathers the top and selected entries; done is registered from READ and is high once the
// sequencer is back in IDLE, where the next transaction may already be accepted. No new
// transaction is taken while busy. Reset clears every valid bit and the entry count; the
// receiver cannot stall results. Depends on osstk_pkg and osstk_cell.
module order_statistic_stack #(
	parameter int DEPTH   = 16,
	parameter int KEY_W   = 32,
	parameter int VALUE_W = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [KEY_W-1:0]           in_key,
	input  logic [VALUE_W-1:0]         in_value,
	input  logic [$clog2(DEPTH+1)-1:0] rank,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [KEY_W-1:0]           sel_key,
	output logic [VALUE_W-1:0]         sel_value,
	output logic                       top_valid,
	output logic [KEY_W-1:0]           top_key,
	output logic [VALUE_W-1:0]         top_value,
	output logic [$clog2(DEPTH+1)-1:0] entry_count
);

	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// The sequencer walks an accepted transaction through its states:
	// EXEC lets the cells shift, READ gathers the result from the settled chain.
	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		READ
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   rank_q;
	logic [CNT_W-1:0]   count_q;
	logic               rank_ok;
	logic [1:0]         exec_status;
	logic               accept;

	logic                  le_chain  [DEPTH+1];
	logic                  vld_chain [DEPTH+2];
	logic [KEY_W-1:0]      key_chain [DEPTH+2];
	logic [VALUE_W-1:0]    val_chain [DEPTH+2];
	logic [POS_W-1:0]      pos_chain [DEPTH+2];
	osstk_pkg::cell_flags_t flags    [DEPTH];
	logic [DEPTH-1:0]      valid_vec;

	osstk_pkg::cell_cmd_t cmd;
	logic [KEY_W-1:0]     ref_key;
	logic [POS_W-1:0]     match_pos;
	logic [POS_W-1:0]     sel_idx;
	logic [KEY_W-1:0]     top_key_or;
	logic [VALUE_W-1:0]   top_value_or;
	logic [KEY_W-1:0]     sel_key_or;
	logic [VALUE_W-1:0]   sel_value_or;

	assign accept = start && !busy;
	assign busy   = (state_q == EXEC) || (state_q == READ);

	// The rank check depends only on the registered rank and the count, which a select does not change.
	assign rank_ok = (rank_q != '0) && (rank_q <= count_q);

	always_comb begin
		exec_status = osstk_pkg::ST_EMPTY;
		unique case (op_q)
			osstk_pkg::OP_PUSH: begin
				exec_status = (count_q == CNT_W'(DEPTH)) ? osstk_pkg::ST_FULL
					: osstk_pkg::ST_DONE;
			end
			osstk_pkg::OP_POP: begin
				exec_status = (count_q != '0) ? osstk_pkg::ST_DONE : osstk_pkg::ST_EMPTY;
			end
			osstk_pkg::OP_SEL: begin
				exec_status = rank_ok ? osstk_pkg::ST_DONE : osstk_pkg::ST_EMPTY;
			end
			default: begin
				exec_status = osstk_pkg::ST_EMPTY;
			end
		endcase
	end

	// Command and compare reference shared by every cell. During a pop the cells compare
	// against the registered top key, which always mirrors the newest entry.
	always_comb begin
		cmd     = osstk_pkg::CMD_HOLD;
		ref_key = key_q;
		if (state_q == EXEC) begin
			if (op_q == osstk_pkg::OP_PUSH && count_q != CNT_W'(DEPTH)) begin
				cmd = osstk_pkg::CMD_PUSH;
			end else if (op_q == osstk_pkg::OP_POP && count_q != '0) begin
				cmd     = osstk_pkg::CMD_POP;
				ref_key = top_key;
			end
		end
	end

	// The newest entry carries stack position count minus one, both before a pop in EXEC
	// and after the update in READ.
	assign match_pos = POS_W'(count_q - CNT_W'(1));
	assign sel_idx   = POS_W'(rank_q - CNT_W'(1));

	// Chain ends: the cell left of the first acts as a kept entry, the one right of the
	// last is empty.
	assign le_chain[0]         = 1'b1;
	assign vld_chain[0]        = 1'b0;
	assign key_chain[0]        = '0;
	assign val_chain[0]        = '0;
	assign pos_chain[0]        = '0;
	assign vld_chain[DEPTH+1]  = 1'b0;
	assign key_chain[DEPTH+1]  = '0;
	assign val_chain[DEPTH+1]  = '0;
	assign pos_chain[DEPTH+1]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		osstk_cell #(
			.KEY_W   (KEY_W),
			.VALUE_W (VALUE_W),
			.POS_W   (POS_W),
			.IDX     (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.ref_key     (ref_key),
			.new_value   (value_q),
			.new_pos     (POS_W'(count_q)),
			.match_pos   (match_pos),
			.sel_idx     (sel_idx),
			.left_le     (le_chain[i]),
			.left_valid  (vld_chain[i]),
			.left_key    (key_chain[i]),
			.left_value  (val_chain[i]),
			.left_pos    (pos_chain[i]),
			.right_valid (vld_chain[i+2]),
			.right_key   (key_chain[i+2]),
			.right_value (val_chain[i+2]),
			.right_pos   (pos_chain[i+2]),
			.flags       (flags[i]),
			.key         (key_chain[i+1]),
			.value       (val_chain[i+1]),
			.pos         (pos_chain[i+1])
		);
		assign le_chain[i+1] = flags[i].le;
		assign vld_chain[i+1] = flags[i].valid;
		assign valid_vec[i]  = flags[i].valid;
	end

	// At most one cell hits for top and one for select, so an OR of gated entries picks it.
	always_comb begin
		top_key_or   = '0;
		top_value_or = '0;
		sel_key_or   = '0;
		sel_value_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (flags[i].top_hit) begin
				top_key_or   = top_key_or | key_chain[i+1];
				top_value_or = top_value_or | val_chain[i+1];
			end
			if (flags[i].sel_hit) begin
				sel_key_or   = sel_key_or | key_chain[i+1];
				sel_value_or = sel_value_or | val_chain[i+1];
			end
		end
	end

	// Sequencer state, transaction registers and registered result ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			count_q   <= '0;
			done      <= 1'b0;
			top_valid <= 1'b0;
			status    <= osstk_pkg::ST_DONE;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					status <= exec_status;
					if (cmd == osstk_pkg::CMD_PUSH) begin
						count_q <= count_q + CNT_W'(1);
					end else if (cmd == osstk_pkg::CMD_POP) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= READ;
				end
				READ: begin
					top_valid <= (count_q != '0);
					done      <= 1'b1;
					state_q   <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			key_q   <= in_key;
			value_q <= in_value;
			rank_q  <= rank;
		end
		if (state_q == READ) begin
			top_key   <= top_key_or;
			top_value <= top_value_or;
			if (op_q == osstk_pkg::OP_SEL && rank_ok) begin
				sel_key   <= sel_key_or;
				sel_value <= sel_value_or;
			end else begin
				sel_key   <= '0;
				sel_value <= '0;
			end
		end
	end

	assign entry_count = count_q;

	// A result never appears while a transaction is still in flight.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// The top flag agrees with the reported count.
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (top_valid == (entry_count != '0)))
		else $error("top_valid disagrees with entry_count");

	// A push into a full stack is reported as dropped.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == osstk_pkg::OP_PUSH && entry_count == CNT_W'(DEPTH))
		|-> ##3 (done && status == osstk_pkg::ST_FULL))
		else $error("push on full stack not flagged");

	// Between transactions the occupied cells match the count.
	a_cell_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE) |-> ($countones(valid_vec) == int'(count_q)))
		else $error("cell valid bits disagree with count");

endmodule

/* rtl/core/osstk_cell.sv */
// One cell of the sorted chain: holds a single key/value entry and its stack position.
// Depends on osstk_pkg for the command and flag types.
// On push it keeps, takes the new entry or takes its left neighbor; on pop it may take its right.
module osstk_cell #(
	parameter int KEY_W   = 32,
	parameter int VALUE_W = 32,
	parameter int POS_W   = 4,
	parameter int IDX     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  osstk_pkg::cell_cmd_t cmd,
	input  logic [KEY_W-1:0]     ref_key,
	input  logic [VALUE_W-1:0]   new_value,
	input  logic [POS_W-1:0]     new_pos,
	input  logic [POS_W-1:0]     match_pos,
	input  logic [POS_W-1:0]     sel_idx,
	input  logic                 left_le,
	input  logic                 left_valid,
	input  logic [KEY_W-1:0]     left_key,
	input  logic [VALUE_W-1:0]   left_value,
	input  logic [POS_W-1:0]     left_pos,
	input  logic                 right_valid,
	input  logic [KEY_W-1:0]     right_key,
	input  logic [VALUE_W-1:0]   right_value,
	input  logic [POS_W-1:0]     right_pos,
	output osstk_pkg::cell_flags_t flags,
	output logic [KEY_W-1:0]     key,
	output logic [VALUE_W-1:0]   value,
	output logic [POS_W-1:0]     pos
);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   pos_q;
	logic               le;
	logic               take_new;
	logic               take_left;
	logic               take_right;

	// Keys not greater than the pushed key stay; the first cell past them takes the new entry.
	assign le         = valid_q && (key_q <= ref_key);
	assign take_new   = (cmd == osstk_pkg::CMD_PUSH) && !le && left_le;
	assign take_left  = (cmd == osstk_pkg::CMD_PUSH) && !le && !left_le;
	// The newest entry is the last of its equal-key group, so everything from it on moves left.
	assign take_right = (cmd == osstk_pkg::CMD_POP) && valid_q &&
		((pos_q == match_pos) || (key_q > ref_key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			key_q   <= ref_key;
			value_q <= new_value;
			pos_q   <= new_pos;
		end else if (take_left) begin
			key_q   <= left_key;
			value_q <= left_value;
			pos_q   <= left_pos;
		end else if (take_right) begin
			key_q   <= right_key;
			value_q <= right_value;
			pos_q   <= right_pos;
		end
	end

	assign flags.valid   = valid_q;
	assign flags.le      = le;
	assign flags.top_hit = valid_q && (pos_q == match_pos);
	assign flags.sel_hit = valid_q && (sel_idx == POS_W'(IDX));
	assign key           = key_q;
	assign value         = value_q;
	assign pos           = pos_q;

endmodule

/* tb/order_statistic_stack_tb.sv */
// Testbench for order_statistic_stack: push, pop and rank select against a behavioral stack.
// Needs osstk_pkg and order_statistic_stack. It stands alone and reads no files.
// A queued driver feeds transactions, and a monitor predicts and checks every result.
module order_statistic_stack_tb;

	localparam int DEPTH   = 16;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Operation code 3 is not decoded by the block. It must leave the stack alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_OPS  = 930;  // random transactions after the directed ones
	localparam int CALM_TAIL   = 150;  // the last transactions are sent back to back
	localparam int STALL_LIMIT = 2000; // cycles with no transaction and no result

	// One transaction waiting to be sent. gap is the idle time in front of it.
	// A set hold_empty makes the driver wait until every outstanding result is back.
	typedef struct {
		logic [1:0]         op;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   rk;
		int                 gap;
		bit                 hold_empty;
	} stack_op_t;

	// One result as the block should report it.
	typedef struct {
		logic [1:0]         status;
		logic [KEY_W-1:0]   sel_key;
		logic [VALUE_W-1:0] sel_value;
		logic               top_valid;
		logic [KEY_W-1:0]   top_key;
		logic [VALUE_W-1:0] top_value;
		logic [CNT_W-1:0]   entry_count;
	} stack_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         operation = osstk_pkg::OP_PUSH;
	logic [KEY_W-1:0]   in_key = '0;
	logic [VALUE_W-1:0] in_value = '0;
	logic [CNT_W-1:0]   rank = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [KEY_W-1:0]   sel_key;
	logic [VALUE_W-1:0] sel_value;
	logic               top_valid;
	logic [KEY_W-1:0]   top_key;
	logic [VALUE_W-1:0] top_value;
	logic [CNT_W-1:0]   entry_count;

	order_statistic_stack #(
		.DEPTH(DEPTH),
		.KEY_W(KEY_W),
		.VALUE_W(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.in_key(in_key),
		.in_value(in_value),
		.rank(rank),
		.done(done),
		.status(status),
		.sel_key(sel_key),
		.sel_value(sel_value),
		.top_valid(top_valid),
		.top_key(top_key),
		.top_value(top_value),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// The stack as the block should hold it, kept in push order: slot 0 is the oldest.
	// Rank order is derived on demand, with equal keys ordered by age, older first.
	logic [KEY_W-1:0]   held_key[DEPTH];
	logic [VALUE_W-1:0] held_value[DEPTH];
	int                 held_depth = 0;

	stack_op_t     op_queue[$];     // transactions not yet handed to the driver
	stack_result_t result_q[$];     // results owed by the block, oldest first
	stack_op_t     cur_op;
	bit            have_cur = 1'b0;
	logic          took = 1'b0;     // the last rising edge accepted a transaction
	int            mismatches = 0;
	int            gen_depth = 0;   // stack depth as the stimulus generator tracks it
	int            n_push = 0, n_full = 0, n_pop = 0, n_sel = 0, n_found = 0;
	int            n_other = 0, peak_depth = 0;
	int            stall_cycles = 0;
	stack_result_t owed, fresh;

	// Applies one transaction to the behavioral stack and works out its result.
	task automatic step_stack(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value, input logic [CNT_W-1:0] rk,
			output stack_result_t res);
		int below;
		res = '{default: '0};
		res.status = osstk_pkg::ST_EMPTY;
		case (op)
			osstk_pkg::OP_PUSH: begin
				if (held_depth >= DEPTH) begin
					res.status = osstk_pkg::ST_FULL;
				end else begin
					held_key[held_depth] = key;
					held_value[held_depth] = value;
					held_depth++;
					res.status = osstk_pkg::ST_DONE;
				end
			end
			osstk_pkg::OP_POP: begin
				if (held_depth > 0) begin
					held_depth--;
					res.status = osstk_pkg::ST_DONE;
				end
			end
			osstk_pkg::OP_SEL: begin
				if (rk >= 1 && int'(rk) <= held_depth) begin
					// An entry's rank is one more than the number of entries ordered
					// ahead of it: smaller keys, and equal keys that were pushed earlier.
					for (int i = 0; i < held_depth; i++) begin
						below = 0;
						for (int j = 0; j < held_depth; j++) begin
							if (held_key[j] < held_key[i] ||
									(held_key[j] == held_key[i] && j < i))
								below++;
						end
						if (below == int'(rk) - 1) begin
							res.sel_key = held_key[i];
							res.sel_value = held_value[i];
						end
					end
					res.status = osstk_pkg::ST_DONE;
				end
			end
			default: begin
			end
		endcase
		if (held_depth > 0) begin
			res.top_valid = 1'b1;
			res.top_key = held_key[held_depth - 1];
			res.top_value = held_value[held_depth - 1];
		end
		res.entry_count = CNT_W'(held_depth);
	endtask

	// Queues one transaction and follows the depth the stack will have after it.
	task automatic add_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value, input logic [CNT_W-1:0] rk,
			input int gap, input bit hold_empty);
		stack_op_t item;
		item.op = op;
		item.key = key;
		item.value = value;
		item.rk = rk;
		item.gap = gap;
		item.hold_empty = hold_empty;
		op_queue.push_back(item);
		if (op == osstk_pkg::OP_PUSH && gen_depth < DEPTH)
			gen_depth++;
		else if (op == osstk_pkg::OP_POP && gen_depth > 0)
			gen_depth--;
	endtask

	// Keys come often from a small pool, so that equal keys and the extremes meet in
	// the stack, and otherwise from the whole range.
	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] pool[8];
		pool = '{32'h0, 32'h1, 32'h2, 32'h7, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFE, 32'hFFFF_FFFF};
		if ($urandom_range(0, 9) < 4)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Driver. A transaction stays on the ports until an edge accepts it. Between
	// transactions the data ports carry noise that the block must ignore.
	always @(negedge clk) begin
		bit go;
		go = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !took)) begin
			if (!have_cur && op_queue.size() != 0) begin
				cur_op = op_queue.pop_front();
				have_cur = 1'b1;
			end
			if (have_cur && cur_op.gap != 0)
				cur_op.gap = cur_op.gap - 1;
			else if (have_cur && cur_op.hold_empty && result_q.size() != 0)
				go = 1'b0;
			else
				go = have_cur;
			if (go) begin
				start <= 1'b1;
				operation <= cur_op.op;
				in_key <= cur_op.key;
				in_value <= cur_op.value;
				rank <= cur_op.rk;
				have_cur = 1'b0;
			end else begin
				start <= 1'b0;
				operation <= 2'($urandom_range(0, 3));
				in_key <= $urandom;
				in_value <= $urandom;
				rank <= CNT_W'($urandom_range(0, 31));
			end
		end
	end

	// Monitor. A result is checked against the oldest owed one before the transaction
	// accepted at the same edge is predicted, since that result belongs to an earlier one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (done) begin
				if (result_q.size() == 0) begin
					$error("result reported with no transaction outstanding");
					mismatches++;
				end else begin
					owed = result_q.pop_front();
					if (status !== owed.status) begin
						$error("status: expected %0d, got %0d", owed.status, status);
						mismatches++;
					end
					if (sel_key !== owed.sel_key) begin
						$error("sel_key: expected %h, got %h", owed.sel_key, sel_key);
						mismatches++;
					end
					if (sel_value !== owed.sel_value) begin
						$error("sel_value: expected %h, got %h", owed.sel_value, sel_value);
						mismatches++;
					end
					if (top_valid !== owed.top_valid) begin
						$error("top_valid: expected %0d, got %0d", owed.top_valid, top_valid);
						mismatches++;
					end
					if (top_key !== owed.top_key) begin
						$error("top_key: expected %h, got %h", owed.top_key, top_key);
						mismatches++;
					end
					if (top_value !== owed.top_value) begin
						$error("top_value: expected %h, got %h", owed.top_value, top_value);
						mismatches++;
					end
					if (entry_count !== owed.entry_count) begin
						$error("entry_count: expected %0d, got %0d", owed.entry_count,
							entry_count);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				step_stack(operation, in_key, in_value, rank, fresh);
				result_q.push_back(fresh);
				case (operation)
					osstk_pkg::OP_PUSH: begin
						n_push++;
						if (fresh.status == osstk_pkg::ST_FULL)
							n_full++;
					end
					osstk_pkg::OP_POP: n_pop++;
					osstk_pkg::OP_SEL: begin
						n_sel++;
						if (fresh.status == osstk_pkg::ST_DONE)
							n_found++;
					end
					default: n_other++;
				endcase
				if (held_depth > peak_depth)
					peak_depth = held_depth;
			end
		end
	end

	// Watchdog: a hung handshake or a lost result stops the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int sent, mode, len, blk, pick;
		logic [1:0] op;
		bit calm, quiet;

		// Directed part: empty-stack corner cases, the key and value extremes, equal
		// keys, every rank from zero to past the count, and the unused operation code.
		add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, 5'd1, 0, 1'b0);
		add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_POP, 32'h0, 32'h0, 5'd0, 0, 1'b0);
		add_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 0, 1'b0);
		add_op(osstk_pkg::OP_PUSH, 32'h0, 32'h0, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_PUSH, 32'h5, 32'hAAAA_AAAA, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_PUSH, 32'h5, 32'h5555_5555, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_PUSH, 32'h0, 32'h1, 5'd0, 0, 1'b0);
		for (int r = 0; r <= 6; r++)
			add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, CNT_W'(r), 0, 1'b0);
		add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, 5'd16, 0, 1'b0);
		add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, 5'd31, 0, 1'b0);
		add_op(OP_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 5'd2, 0, 1'b0);
		add_op(osstk_pkg::OP_POP, 32'h0, 32'h0, 5'd0, 0, 1'b0);
		add_op(osstk_pkg::OP_SEL, 32'h0, 32'h0, 5'd2, 0, 1'b0);
		repeat (4)
			add_op(osstk_pkg::OP_POP, 32'h0, 32'h0, 5'd0, 0, 1'b0);

		// Random part, in blocks that each lean one way: filling the stack up to and
		// past full, emptying it, querying ranks, or plain noise. Some blocks send
		// back to back and others idle in bursts; every eighth block outside the calm tail
		// first waits for the block to answer everything it owes.
		sent = 0;
		blk = 0;
		while (sent < RANDOM_OPS) begin
			mode = (blk == 0) ? 0 : $urandom_range(0, 3);
			len = (blk == 0) ? 30 : $urandom_range(8, 40);
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len && sent < RANDOM_OPS; i++) begin
				pick = $urandom_range(0, 99);
				case (mode)
					0: op = (pick < 85) ? osstk_pkg::OP_PUSH :
						(pick < 96) ? osstk_pkg::OP_SEL : osstk_pkg::OP_POP;
					1: op = (pick < 70) ? osstk_pkg::OP_POP :
						(pick < 95) ? osstk_pkg::OP_SEL : osstk_pkg::OP_PUSH;
					2: op = (pick < 70) ? osstk_pkg::OP_SEL :
						(pick < 85) ? osstk_pkg::OP_PUSH : osstk_pkg::OP_POP;
					default: op = 2'($urandom_range(0, 3));
				endcase
				if (mode != 3 && $urandom_range(0, 49) == 0)
					op = OP_UNUSED;
				calm = (sent >= RANDOM_OPS - CALM_TAIL);
				add_op(op, pick_key(), $urandom,
					(mode == 3 || $urandom_range(0, 6) == 0) ?
						CNT_W'($urandom_range(0, 31)) :
						CNT_W'($urandom_range(gen_depth == 0 ? 0 : 1,
							gen_depth == 0 ? 1 : gen_depth)),
					(!calm && !quiet && $urandom_range(0, 4) == 0) ?
						$urandom_range(1, 15) : 0,
					!calm && i == 0 && blk % 8 == 0);
				sent++;
			end
			blk++;
		end

		// Reset is held low at the start and released at a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Let every transaction go out and every owed result come back, then keep the clock
		// running on idle ports so that any stray result still shows.
		while (op_queue.size() != 0 || have_cur || start || result_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d pushes (%0d dropped on a full stack), %0d pops, %0d selects",
			n_push, n_full, n_pop, n_sel);
		$display("(%0d found), %0d unused-code transactions; deepest stack %0d of %0d.",
			n_found, n_other, peak_depth, DEPTH);
		if (mismatches == 0 && result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/core/osstk_pkg.sv
rtl/core/osstk_cell.sv
rtl/core/order_statistic_stack.sv
tb/order_statistic_stack_tb.sv
